>>> sv/toeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_pkg: shared types and constants for the time-ordered event queue
// Entry layout, command codes, kind codes and ring index arithmetic.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 7;
  localparam int TIME_W   = 64;
  localparam int KIND_W   = 4;
  localparam int PAY_W    = 64;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_BOUND = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_TAKE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RESET     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_FIRST_USR = 4'd2;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  // Ring position of an offset from the head; both terms stay below CAPACITY
  // (offset may equal CAPACITY-1 at most), so one conditional subtract wraps.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> sv/time_ordered_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_event_queue_top: timestamp-sorted event ring buffer
// Insertion-sorted queue held in one synchronous memory, with publish bound,
// kind-checked pop and an overflow reset-pending flag.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------
// command   | start & !busy         | cmd, event_time, event_kind, event_payload,
//           |                       | bound_time, want_kind
// result    | result_strobe (1 cyc) | done_res, overflowed, next_kind, out_time,
//           |                       | out_kind, out_payload, fill_count
//
// Sequence: each item ends with a head read and the result strobe. A pop that
// succeeds does a second head read to refresh the visible kind. A push moves
// entries one at a time toward the tail, each read and then rewritten one slot
// later, until a compare finds the insert point or every held entry has moved.
// Reset: rst clears head, count, flags and bound; the memory needs no clearing
// because only written entries are ever read. The receiver cannot stall: the
// result is on the ports for exactly the strobe cycle, and busy drops then.

module time_ordered_event_queue_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [toeq_pkg::TIME_W-1:0]  event_time,
  input  logic [toeq_pkg::KIND_W-1:0]  event_kind,
  input  logic [toeq_pkg::PAY_W-1:0]   event_payload,
  input  logic [toeq_pkg::TIME_W-1:0]  bound_time,
  input  logic [toeq_pkg::KIND_W-1:0]  want_kind,
  output logic                         result_strobe,
  output logic                         done_res,
  output logic                         overflowed,
  output logic [toeq_pkg::KIND_W-1:0]  next_kind,
  output logic [toeq_pkg::TIME_W-1:0]  out_time,
  output logic [toeq_pkg::KIND_W-1:0]  out_kind,
  output logic [toeq_pkg::PAY_W-1:0]   out_payload,
  output logic [toeq_pkg::FILL_W-1:0]  fill_count
);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_RD  = 3'd1;  // read entry before insert point
  localparam logic [2:0] S_PUSH_CMP = 3'd2;  // compare, then shift or place
  localparam logic [2:0] S_HEAD_RD  = 3'd3;  // read head entry
  localparam logic [2:0] S_HEAD_CHK = 3'd4;  // evaluate head: pop or report

  logic [2:0] state;

  // Queue control state
  logic [toeq_pkg::IDX_W-1:0]  head;
  logic [toeq_pkg::CNT_W-1:0]  count;
  logic                        reset_flag;
  logic                        bound_active;
  logic [toeq_pkg::TIME_W-1:0] bound_value;

  // Item under work
  logic [toeq_pkg::TIME_W-1:0] ev_time;
  logic [toeq_pkg::KIND_W-1:0] ev_kind;
  logic [toeq_pkg::PAY_W-1:0]  ev_pay;
  logic [toeq_pkg::KIND_W-1:0] want;
  logic                        pop_pend;
  logic [toeq_pkg::CNT_W-1:0]  pos;       // current insertion offset from head

  // Event memory: one read and one write port, registered read data
  toeq_pkg::entry_t           mem [toeq_pkg::CAPACITY];
  toeq_pkg::entry_t           rd_data;
  toeq_pkg::entry_t           wr_data;
  toeq_pkg::entry_t           new_entry;
  logic [toeq_pkg::IDX_W-1:0] rd_addr;
  logic [toeq_pkg::IDX_W-1:0] wr_addr;
  logic                       wr_en;

  logic                        place_here;  // entry before pos is not later
  logic [toeq_pkg::KIND_W-1:0] vis_kind;
  logic [toeq_pkg::IDX_W-1:0]  head_inc;
  logic                        push_ok;     // user kind pushed, no reset pending
  logic                        queue_full;
  logic                        pop_now;     // pop request matches visible head

  assign new_entry = '{stamp: ev_time, kind: ev_kind, payload: ev_pay};

  assign place_here = (rd_data.stamp <= ev_time);
  assign head_inc   = (head == toeq_pkg::IDX_W'(toeq_pkg::CAPACITY - 1)) ?
                      '0 : head + 1'b1;

  assign push_ok    = (cmd == toeq_pkg::CMD_PUSH) &&
                      (event_kind >= toeq_pkg::KIND_FIRST_USR) && !reset_flag;
  assign queue_full = (count == toeq_pkg::CNT_W'(toeq_pkg::CAPACITY));
  assign pop_now    = pop_pend && (want >= toeq_pkg::KIND_FIRST_USR) &&
                      (vis_kind == want);

  // Visible head kind, valid in S_HEAD_CHK when rd_data holds the head
  always_comb begin
    if (reset_flag) begin
      vis_kind = toeq_pkg::KIND_RESET;
    end else if (count == '0) begin
      vis_kind = toeq_pkg::KIND_NONE;
    end else if (bound_active && (rd_data.stamp >= bound_value)) begin
      vis_kind = toeq_pkg::KIND_NONE;
    end else begin
      vis_kind = rd_data.kind;
    end
  end

  // Memory address and write control
  always_comb begin
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = new_entry;
    case (state)
      S_PUSH_RD: begin
        // Fetch the entry just ahead of the insertion point; when pos is
        // zero the new event becomes the head.
        rd_addr = toeq_pkg::ring_pos(head, pos - 1'b1);
        if (pos == '0) begin
          wr_en = 1'b1;
        end
      end
      S_PUSH_CMP: begin
        // Either place the new event, or shift the older one a slot tailward
        wr_en   = 1'b1;
        wr_addr = toeq_pkg::ring_pos(head, pos);
        wr_data = place_here ? new_entry : rd_data;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      reset_flag    <= 1'b0;
      bound_active  <= 1'b0;
      bound_value   <= '0;
      pop_pend      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      // Strobe once the head check has nothing more to pop
      result_strobe <= (state == S_HEAD_CHK) && !pop_now;
      case (state)
        S_IDLE: begin
          if (start) begin
            ev_time     <= event_time;
            ev_kind     <= event_kind;
            ev_pay      <= event_payload;
            want        <= want_kind;
            pop_pend    <= (cmd == toeq_pkg::CMD_POP);
            done_res    <= (cmd == toeq_pkg::CMD_TAKE) && reset_flag;
            overflowed  <= push_ok && queue_full;
            out_time    <= '0;
            out_kind    <= '0;
            out_payload <= '0;
            state       <= (push_ok && !queue_full) ? S_PUSH_RD : S_HEAD_RD;
            case (cmd)
              toeq_pkg::CMD_PUSH: begin
                if (push_ok) begin
                  if (queue_full) begin
                    // Full: drop everything and raise reset pending
                    head       <= '0;
                    count      <= '0;
                    reset_flag <= 1'b1;
                  end else begin
                    pos <= count;
                  end
                end
              end
              toeq_pkg::CMD_BOUND: begin
                bound_active <= 1'b1;
                bound_value  <= bound_time;
              end
              toeq_pkg::CMD_TAKE: begin
                reset_flag <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH_RD: begin
          if (pos == '0) begin
            count    <= count + 1'b1;
            done_res <= 1'b1;
            state    <= S_HEAD_RD;
          end else begin
            state <= S_PUSH_CMP;
          end
        end
        S_PUSH_CMP: begin
          if (place_here) begin
            count    <= count + 1'b1;
            done_res <= 1'b1;
            state    <= S_HEAD_RD;
          end else begin
            pos   <= pos - 1'b1;
            state <= S_PUSH_RD;
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_CHK;
        end
        S_HEAD_CHK: begin
          if (pop_now) begin
            // Pop the head, then reread the new head for the visible kind
            out_time    <= rd_data.stamp;
            out_kind    <= rd_data.kind;
            out_payload <= rd_data.payload;
            head        <= head_inc;
            count       <= count - 1'b1;
            done_res    <= 1'b1;
            pop_pend    <= 1'b0;
            state       <= S_HEAD_RD;
          end else begin
            next_kind <= vis_kind;
            pop_pend  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign fill_count = toeq_pkg::FILL_W'(count);

endmodule

>>> tb/tb_time_ordered_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_ordered_event_queue_top: self-checking bench for the event queue
// Sends push, publish, pop and take-reset items with random idle gaps, keeps
// a mirror of the sorted ring and checks every strobed result against it.
// ----------------------------------------------------------------------------
module tb_time_ordered_event_queue_top;

  localparam int CAPACITY = toeq_pkg::CAPACITY;
  localparam int TIME_W   = toeq_pkg::TIME_W;
  localparam int KIND_W   = toeq_pkg::KIND_W;
  localparam int PAY_W    = toeq_pkg::PAY_W;
  localparam int FILL_W   = toeq_pkg::FILL_W;

  localparam logic [1:0] CMD_PUSH  = toeq_pkg::CMD_PUSH;
  localparam logic [1:0] CMD_BOUND = toeq_pkg::CMD_BOUND;
  localparam logic [1:0] CMD_POP   = toeq_pkg::CMD_POP;
  localparam logic [1:0] CMD_TAKE  = toeq_pkg::CMD_TAKE;

  localparam logic [KIND_W-1:0] KIND_NONE      = toeq_pkg::KIND_NONE;
  localparam logic [KIND_W-1:0] KIND_RESET     = toeq_pkg::KIND_RESET;
  localparam logic [KIND_W-1:0] KIND_FIRST_USR = toeq_pkg::KIND_FIRST_USR;

  localparam int ITEM_TARGET  = 1900;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Longest push shifts every held entry; the wait covers it with room to spare.
  localparam int SETTLE_WAIT  = 2 * CAPACITY + 16;
  localparam int REPORT_LIMIT = 10;
  localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

  // One result as the block reports it; field order follows the ports.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [KIND_W-1:0] shown;
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [PAY_W-1:0]  payload;
    logic [FILL_W-1:0] fill;
  } reply_t;

  // Mirror of the sorted ring: note_item applies an accepted item and queues
  // the result it must cause; check_result compares a strobed result with
  // the oldest queued one.
  class event_queue_mirror;
    logic [TIME_W-1:0] stamps   [CAPACITY];
    logic [KIND_W-1:0] kinds    [CAPACITY];
    logic [PAY_W-1:0]  payloads [CAPACITY];
    int                head;
    int                held;
    bit                pending;
    bit                bound_on;
    logic [TIME_W-1:0] bound_val;
    reply_t            due_results[$];
    int                mismatches;
    int                checked;
    int                stored;
    int                popped;
    int                overflows;
    int                takes_hit;

    function new();
      head      = 0;
      held      = 0;
      pending   = 1'b0;
      bound_on  = 1'b0;
      bound_val = '0;
    endfunction

    // Kind a pop would see right now.
    function logic [KIND_W-1:0] shown_kind();
      if (pending) return KIND_RESET;
      if (held == 0) return KIND_NONE;
      if (bound_on && stamps[head] >= bound_val) return KIND_NONE;
      return kinds[head];
    endfunction

    function void note_item(input logic [1:0] op, input logic [TIME_W-1:0] t,
                            input logic [KIND_W-1:0] k, input logic [PAY_W-1:0] p,
                            input logic [TIME_W-1:0] b, input logic [KIND_W-1:0] w);
      reply_t r;
      int     pos;
      int     cur;
      int     prev;
      r = '0;
      case (op)
        CMD_PUSH: begin
          if (k >= KIND_FIRST_USR && !pending) begin
            if (held >= CAPACITY) begin
              // Full: drop everything, raise the pending flag, drop the event.
              head    = 0;
              held    = 0;
              pending = 1'b1;
              r.ovf   = 1'b1;
              overflows++;
            end else begin
              // Shift later stamps toward the tail; equal stamps stay ahead.
              pos = held;
              while (pos > 0 && stamps[(head + pos - 1) % CAPACITY] > t) begin
                prev = (head + pos - 1) % CAPACITY;
                cur  = (head + pos) % CAPACITY;
                stamps[cur]   = stamps[prev];
                kinds[cur]    = kinds[prev];
                payloads[cur] = payloads[prev];
                pos--;
              end
              cur = (head + pos) % CAPACITY;
              stamps[cur]   = t;
              kinds[cur]    = k;
              payloads[cur] = p;
              held++;
              r.done = 1'b1;
              stored++;
            end
          end
        end
        CMD_BOUND: begin
          bound_on  = 1'b1;
          bound_val = b;
        end
        CMD_POP: begin
          if (w >= KIND_FIRST_USR && shown_kind() == w) begin
            r.stamp   = stamps[head];
            r.kind    = kinds[head];
            r.payload = payloads[head];
            head      = (head + 1) % CAPACITY;
            held--;
            r.done    = 1'b1;
            popped++;
          end
        end
        default: begin
          r.done  = pending;
          if (pending) takes_hit++;
          pending = 1'b0;
        end
      endcase
      r.shown = shown_kind();
      r.fill  = FILL_W'(held);
      due_results.push_back(r);
    endfunction

    function void check_result(input reply_t got);
      reply_t want;
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: done=%0d ovf=%0d next=%0d fill=%0d",
                   $time, got.done, got.ovf, got.shown, got.fill);
        return;
      end
      want = due_results.pop_front();
      if (got.done !== want.done || got.ovf !== want.ovf || got.shown !== want.shown ||
          got.stamp !== want.stamp || got.kind !== want.kind ||
          got.payload !== want.payload || got.fill !== want.fill) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result mismatch", $time);
          $display("  exp done=%0d ovf=%0d next=%0d time=%h kind=%0d pay=%h fill=%0d",
                   want.done, want.ovf, want.shown, want.stamp, want.kind, want.payload,
                   want.fill);
          $display("  got done=%0d ovf=%0d next=%0d time=%h kind=%0d pay=%h fill=%0d",
                   got.done, got.ovf, got.shown, got.stamp, got.kind, got.payload, got.fill);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        cmd = CMD_PUSH;
  logic [TIME_W-1:0] event_time = '0;
  logic [KIND_W-1:0] event_kind = KIND_NONE;
  logic [PAY_W-1:0]  event_payload = '0;
  logic [TIME_W-1:0] bound_time = '0;
  logic [KIND_W-1:0] want_kind = KIND_NONE;
  logic              busy;
  logic              result_strobe;
  logic              done_res;
  logic              overflowed;
  logic [KIND_W-1:0] next_kind;
  logic [TIME_W-1:0] out_time;
  logic [KIND_W-1:0] out_kind;
  logic [PAY_W-1:0]  out_payload;
  logic [FILL_W-1:0] fill_count;

  event_queue_mirror mirror;
  int                cycles = 0;
  int                sent = 0;
  int                useful = 0;
  bit                calm = 1'b0;
  logic [TIME_W-1:0] epoch = '0;

  time_ordered_event_queue_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .event_time    (event_time),
    .event_kind    (event_kind),
    .event_payload (event_payload),
    .bound_time    (bound_time),
    .want_kind     (want_kind),
    .result_strobe (result_strobe),
    .done_res      (done_res),
    .overflowed    (overflowed),
    .next_kind     (next_kind),
    .out_time      (out_time),
    .out_kind      (out_kind),
    .out_payload   (out_payload),
    .fill_count    (fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the block hangs or stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: gave up after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Results cannot be held off, so take every strobe on the edge that ends it.
  always @(posedge clk) begin
    reply_t got;
    if (!rst && result_strobe) begin
      got = {done_res, overflowed, next_kind, out_time, out_kind, out_payload, fill_count};
      mirror.check_result(got);
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Half the stamps tiny so that equal times and deep shifts are common; some
  // near the phase epoch, some anywhere in the 64-bit range.
  function automatic logic [TIME_W-1:0] rand_stamp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return TIME_W'($urandom_range(0, 31));
      5, 6, 7:       return epoch + TIME_W'($urandom_range(0, 4095));
      default:       return rand_word();
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_bound();
    case ($urandom_range(0, 7))
      0, 1, 2: return ALL_ONES;
      3:       return '0;
      4:       return rand_word();
      default: return rand_stamp();
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_push_kind();
    if ($urandom_range(0, 19) == 0) return KIND_W'($urandom_range(0, 1));
    return KIND_W'($urandom_range(KIND_FIRST_USR, 15));
  endfunction

  // Send one item: idle for a drawn gap (none in calm phases), present it,
  // hold until the block takes it, then note it in the mirror.
  task automatic issue(input logic [1:0] op, input logic [TIME_W-1:0] t,
                       input logic [KIND_W-1:0] k, input logic [PAY_W-1:0] p,
                       input logic [TIME_W-1:0] b, input logic [KIND_W-1:0] w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    cmd           <= op;
    event_time    <= t;
    event_kind    <= k;
    event_payload <= p;
    bound_time    <= b;
    want_kind     <= w;
    do @(posedge clk); while (busy);
    // Pushes that the block drops on sight do not count toward the target.
    if (!(op == CMD_PUSH && (k < KIND_FIRST_USR || mirror.pending))) useful++;
    mirror.note_item(op, t, k, p, b, w);
    sent++;
  endtask

  task automatic push_any();
    issue(CMD_PUSH, rand_stamp(), rand_push_kind(), rand_word(), rand_word(),
          KIND_W'($urandom_range(0, 15)));
  endtask

  task automatic publish_any(input logic [TIME_W-1:0] b);
    issue(CMD_BOUND, rand_word(), KIND_W'($urandom_range(0, 15)), rand_word(), b,
          KIND_W'($urandom_range(0, 15)));
  endtask

  task automatic pop_kind(input logic [KIND_W-1:0] w);
    issue(CMD_POP, rand_word(), KIND_W'($urandom_range(0, 15)), rand_word(), rand_word(), w);
  endtask

  task automatic take_flag();
    issue(CMD_TAKE, rand_word(), KIND_W'($urandom_range(0, 15)), rand_word(), rand_word(),
          KIND_W'($urandom_range(0, 15)));
  endtask

  // Pop what is showing most of the time so the ring drains; otherwise guess.
  task automatic pop_likely();
    logic [KIND_W-1:0] vis;
    vis = mirror.shown_kind();
    if (vis >= KIND_FIRST_USR && $urandom_range(0, 99) < 85) pop_kind(vis);
    else pop_kind(KIND_W'($urandom_range(0, 15)));
  endtask

  initial begin
    int n;
    logic [KIND_W-1:0] vis;
    mirror = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, reserved kinds, extremes, equal stamps, bounds.
    take_flag();                                   // flag clear: nothing taken
    pop_kind(KIND_NONE);                           // reserved want on empty queue
    pop_kind(KIND_RESET);
    pop_kind(4'd15);                               // empty: nothing visible
    issue(CMD_PUSH, 64'd9, KIND_NONE, ALL_ONES, '0, KIND_NONE);   // reserved kind dropped
    issue(CMD_PUSH, 64'd9, KIND_RESET, ALL_ONES, '0, KIND_NONE);
    issue(CMD_PUSH, ALL_ONES, 4'd15, ALL_ONES, ALL_ONES, 4'd15);  // latest possible stamp
    issue(CMD_PUSH, '0, KIND_FIRST_USR, '0, '0, KIND_NONE);      // earliest: shifts to head
    issue(CMD_PUSH, 64'd5, 4'd7, 64'h0123_4567_89ab_cdef, '0, KIND_NONE);
    issue(CMD_PUSH, 64'd5, 4'd8, 64'hfedc_ba98_7654_3210, '0, KIND_NONE); // equal stamp
    issue(CMD_PUSH, 64'd5, 4'd9, 64'h5555_aaaa_5555_aaaa, '0, KIND_NONE);
    pop_kind(KIND_RESET);                          // reserved want never pops
    pop_kind(4'd3);                                // wrong kind
    pop_kind(KIND_FIRST_USR);                      // stamp 0 leaves
    publish_any(64'd5);                            // head at the bound: hidden
    pop_kind(4'd7);
    publish_any(64'd6);                            // now strictly below
    pop_kind(4'd7);
    pop_kind(4'd8);
    pop_kind(4'd9);
    publish_any(ALL_ONES);                         // all-ones stamp still hidden
    pop_kind(4'd15);
    publish_any('0);
    take_flag();

    // Random phases: fill runs that often overflow, drain runs that pop what
    // shows, and loose mixes of every command with any field values.
    while (useful < ITEM_TARGET) begin
      calm  = ($urandom_range(0, 3) == 0);
      epoch = $urandom_range(0, 1) ? '0 : rand_word();
      case ($urandom_range(0, 5))
        0, 1: begin
          n = $urandom_range(20, 80);
          repeat (n) begin
            if (mirror.pending && $urandom_range(0, 3) == 0) take_flag();
            else if ($urandom_range(0, 9) == 0) pop_likely();
            else if ($urandom_range(0, 19) == 0) publish_any(rand_bound());
            else push_any();
          end
        end
        2, 3: begin
          publish_any(rand_bound());
          n = $urandom_range(5, 70);
          repeat (n) begin
            vis = mirror.shown_kind();
            if (vis == KIND_RESET && $urandom_range(0, 2) == 0) take_flag();
            else if (vis == KIND_NONE && mirror.held > 0 && $urandom_range(0, 2) == 0)
              publish_any($urandom_range(0, 1) ? ALL_ONES : rand_bound());
            else if ($urandom_range(0, 9) == 0) push_any();
            else pop_likely();
          end
        end
        default: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0:       push_any();
              1:       publish_any(rand_bound());
              2:       pop_likely();
              default: take_flag();
            endcase
          end
        end
      endcase
    end

    // Stop sending, let every owed result arrive, then watch for strays.
    start <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked, %0d events stored, %0d popped",
             sent, mirror.checked, mirror.stored, mirror.popped);
    $display("tb: %0d overflows, %0d pending resets taken, %0d mismatches",
             mirror.overflows, mirror.takes_hit, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
